/* src/sqbvg_pkg.sv */
// Package for the sprite quad batch vertex generator.
// Holds state enum, sine table, shared constants and control structs. No dependencies.
`default_nettype none
package sqbvg_pkg;

    localparam int MAX_QUADS_DEF     = 16384;
    localparam int TEXTURE_SLOTS_DEF = 32;

    localparam logic [1:0] REG_U_LEFT   = 2'd0;
    localparam logic [1:0] REG_U_RIGHT  = 2'd1;
    localparam logic [1:0] REG_V_BOTTOM = 2'd2;
    localparam logic [1:0] REG_V_TOP    = 2'd3;

    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_FLUSH  = 1'b1;

    localparam logic CMD_DRAW = 1'b0;
    localparam logic CMD_END  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREFLUSH,
        ST_SEARCH,
        ST_SLOTFLUSH,
        ST_TRIG,
        ST_MUL,
        ST_SUM,
        ST_EMIT,
        ST_ENDFLUSH
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture input item
        logic search_step; // compare one slot table entry
        logic search_init;
        logic new_slot;    // allocate slot for current id
        logic trig;        // sine/cos lookup
        logic mul;         // products for current corner
        logic sum;         // round, add, saturate
        logic emit_vert;   // load output register with vertex
        logic emit_flush;  // load output register with flush record
        logic last;
        logic reset_batch;
        logic next_corner;
        logic count_quad;
    } ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic is_end;
        logic textured;
        logic batch_full;
        logic batch_empty;
        logic search_done;
        logic found;
        logic slots_full;
        logic corner_last;
        logic out_busy;
    } stat_t;

    function automatic logic [15:0] qsine(input logic [5:0] k);
        logic [15:0] r;
        case (k)
            6'd0:  r = 16'd0;     6'd1:  r = 16'd1608;  6'd2:  r = 16'd3212;
            6'd3:  r = 16'd4808;  6'd4:  r = 16'd6393;  6'd5:  r = 16'd7962;
            6'd6:  r = 16'd9512;  6'd7:  r = 16'd11039; 6'd8:  r = 16'd12540;
            6'd9:  r = 16'd14010; 6'd10: r = 16'd15447; 6'd11: r = 16'd16846;
            6'd12: r = 16'd18205; 6'd13: r = 16'd19520; 6'd14: r = 16'd20788;
            6'd15: r = 16'd22006; 6'd16: r = 16'd23170; 6'd17: r = 16'd24279;
            6'd18: r = 16'd25330; 6'd19: r = 16'd26320; 6'd20: r = 16'd27246;
            6'd21: r = 16'd28106; 6'd22: r = 16'd28899; 6'd23: r = 16'd29622;
            6'd24: r = 16'd30274; 6'd25: r = 16'd30853; 6'd26: r = 16'd31357;
            6'd27: r = 16'd31786; 6'd28: r = 16'd32138; 6'd29: r = 16'd32413;
            6'd30: r = 16'd32610; 6'd31: r = 16'd32729;
            default: r = 16'd32768;
        endcase
        return r;
    endfunction

    // Q1.15 sine, 17-bit signed, of an angle in 1/65536 turn
    function automatic logic signed [16:0] sine_q15(input logic [15:0] a);
        logic [14:0] pos;
        logic [5:0]  idx;
        logic [8:0]  frac;
        logic [15:0] lo;
        logic [15:0] d;
        logic [25:0] p;
        logic [16:0] v;
        pos = a[14] ? (15'd16384 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
        idx = pos[14:9];
        frac = pos[8:0];
        lo = qsine(idx);
        d = qsine(idx + 6'd1) - lo;
        p = {10'd0, d} * {17'd0, frac} + 26'd256;
        v = (idx >= 6'd32) ? 17'd32768 : ({1'b0, lo} + p[25:9]);
        return a[15] ? -$signed(v) : $signed(v);
    endfunction

endpackage
`default_nettype wire

/* src/sprite_quad_batch_vertex_gen.sv */
// Top level of the sprite quad batch vertex generator.
// Depends on sqbvg_pkg, sqbvg_ctrl, sqbvg_datapath.
`default_nettype none
// One item at a time. From acceptance until the input is ready again, an untextured
// draw takes the item, does the batch check and the sine/cosine lookup, then does
// multiply, round/add and output load for each of the four corners on the shared
// arithmetic. A textured draw adds a slot search that compares one slot table entry
// per step (up to TEXTURE_SLOTS-1); a full slot table adds a flush step. An end
// scene takes the item and then emits its flush, if the batch is not empty.
// Output back-pressure stretches any of these.
module sprite_quad_batch_vertex_gen
    import sqbvg_pkg::*;
#(
    parameter int MAX_QUADS     = MAX_QUADS_DEF,
    parameter int TEXTURE_SLOTS = TEXTURE_SLOTS_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_idx,
    input  wire logic [15:0]  cfg_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // centre_x, centre_y, depth_z, angle, width, height, rgba, texture_id, tiling
    input  wire logic [239:0] s_tdata,
    // cmd, textured
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // vert_x, vert_y, vert_z, vert_rgba, tex_u, tex_v, slot, vert_tiling,
    // batch_quads, batch_slots, pad
    output logic [207:0]      m_tdata,
    // kind
    output logic              m_tuser,
    output logic              m_tlast
);
    logic  busy, in_fire;
    ctrl_t ctrl;
    stat_t stat;

    assign s_tready = !busy;
    assign in_fire  = s_tvalid && s_tready;

    sqbvg_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .busy(busy),
        .stat(stat), .ctrl(ctrl)
    );

    sqbvg_datapath #(.MAX_QUADS(MAX_QUADS), .TEXTURE_SLOTS(TEXTURE_SLOTS)) u_dp (
        .clk(clk), .rst_n(rst_n), .in_data(s_tdata[207:0]), .in_user(s_tuser[0]),
        .in_side({s_tuser[1], s_tdata[223:208], s_tdata[239:224]}),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
        .ctrl(ctrl), .stat(stat), .out_valid(m_tvalid), .out_ready(m_tready),
        .out_data(m_tdata), .out_user(m_tuser), .out_last(m_tlast)
    );
endmodule
`default_nettype wire

/* src/sqbvg_ctrl.sv */
// Controller state machine for the sprite quad batch vertex generator.
// Depends on sqbvg_pkg.
`default_nettype none
module sqbvg_ctrl
    import sqbvg_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_fire,
    output logic       busy,
    input  wire stat_t stat,
    output ctrl_t      ctrl
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_fire)
                    state_next = ST_PREFLUSH;
            ST_PREFLUSH:
                if (stat.is_end)
                begin
                    if (!stat.out_busy)
                        state_next = ST_IDLE;
                end
                else if (!(stat.batch_full && !stat.batch_empty && stat.out_busy))
                    state_next = stat.textured ? ST_SEARCH : ST_TRIG;
            ST_SEARCH:
                if (stat.search_done)
                    state_next = (stat.found || !stat.slots_full) ? ST_TRIG : ST_SLOTFLUSH;
            ST_SLOTFLUSH:
                if (stat.batch_empty || !stat.out_busy)
                    state_next = ST_TRIG;
            ST_TRIG:
                state_next = ST_MUL;
            ST_MUL:
                state_next = ST_SUM;
            ST_SUM:
                state_next = ST_EMIT;
            ST_EMIT:
                if (!stat.out_busy)
                    state_next = stat.corner_last ? ST_IDLE : ST_MUL;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            ST_IDLE:
                ctrl.load = in_fire;
            ST_PREFLUSH:
                if (stat.is_end)
                begin
                    if (!stat.out_busy)
                    begin
                        ctrl.emit_flush  = !stat.batch_empty;
                        ctrl.last        = 1'b1;
                        ctrl.reset_batch = 1'b1;
                    end
                end
                else if (stat.batch_full)
                begin
                    if (stat.batch_empty || !stat.out_busy)
                    begin
                        ctrl.emit_flush  = !stat.batch_empty;
                        ctrl.reset_batch = 1'b1;
                        ctrl.search_init = 1'b1;
                    end
                end
                else
                    ctrl.search_init = 1'b1;
            ST_SEARCH:
                if (!stat.search_done)
                    ctrl.search_step = 1'b1;
                else if (!stat.found && !stat.slots_full)
                    ctrl.new_slot = 1'b1;
            ST_SLOTFLUSH:
                if (stat.batch_empty || !stat.out_busy)
                begin
                    ctrl.emit_flush  = !stat.batch_empty;
                    ctrl.reset_batch = 1'b1;
                    ctrl.new_slot    = 1'b1;
                end
            ST_TRIG:
                ctrl.trig = 1'b1;
            ST_MUL:
                ctrl.mul = 1'b1;
            ST_SUM:
                ctrl.sum = 1'b1;
            ST_EMIT:
                if (!stat.out_busy)
                begin
                    ctrl.emit_vert   = 1'b1;
                    ctrl.last        = stat.corner_last;
                    ctrl.next_corner = 1'b1;
                    ctrl.count_quad  = stat.corner_last;
                end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

/* src/sqbvg_datapath.sv */
// Datapath for the sprite quad batch vertex generator: slot table, trig, corner math,
// output register. Depends on sqbvg_pkg.
`default_nettype none
module sqbvg_datapath
    import sqbvg_pkg::*;
#(
    parameter int MAX_QUADS     = MAX_QUADS_DEF,
    parameter int TEXTURE_SLOTS = TEXTURE_SLOTS_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic [207:0] in_data,
    input  wire logic         in_user,
    // tiling, texture_id, textured
    input  wire logic [32:0]  in_side,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_idx,
    input  wire logic [15:0]  cfg_data,
    input  wire ctrl_t        ctrl,
    output stat_t             stat,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [207:0]      out_data,
    output logic              out_user,
    output logic              out_last
);

    logic [15:0] u_left_reg, u_right_reg, v_bottom_reg, v_top_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_left_reg   <= 16'd13653;
            u_right_reg  <= 16'd16384;
            v_bottom_reg <= 16'd23831;
            v_top_reg    <= 16'd26810;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_U_LEFT:   u_left_reg   <= cfg_data;
                REG_U_RIGHT:  u_right_reg  <= cfg_data;
                REG_V_BOTTOM: v_bottom_reg <= cfg_data;
                REG_V_TOP:    v_top_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // captured item
    logic               cmd_reg, tex_reg;
    logic signed [31:0] cx_reg, cy_reg, w_reg, h_reg;
    logic [31:0]        z_reg, rgba_reg;
    logic [15:0]        angle_reg, id_reg, tiling_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg    <= in_user;
            cx_reg     <= in_data[31:0];
            cy_reg     <= in_data[63:32];
            z_reg      <= in_data[95:64];
            angle_reg  <= in_data[111:96];
            w_reg      <= in_data[143:112];
            h_reg      <= in_data[175:144];
            rgba_reg   <= in_data[207:176];
            tex_reg    <= in_side[32];
            id_reg     <= in_side[31:16];
            tiling_reg <= in_side[15:0];
        end
    end

    // batch state
    localparam int SW = $clog2(TEXTURE_SLOTS + 1);
    localparam int IW = $clog2(TEXTURE_SLOTS);
    logic [15:0]   quads_reg;
    logic [SW-1:0] slots_reg;
    logic [SW-1:0] search_reg;
    logic          found_reg;
    logic [IW-1:0] slot_reg;
    logic [1:0]    corner_reg;
    logic [15:0]   slot_texture [TEXTURE_SLOTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quads_reg  <= '0;
            slots_reg  <= SW'(1);
            search_reg <= '0;
            found_reg  <= 1'b0;
            slot_reg   <= '0;
            corner_reg <= '0;
        end
        else
        begin
            if (ctrl.reset_batch)
                quads_reg <= '0;
            else if (ctrl.count_quad)
                quads_reg <= quads_reg + 16'd1;
            if (ctrl.new_slot)
                slots_reg <= ctrl.reset_batch ? SW'(2) : slots_reg + SW'(1);
            else if (ctrl.reset_batch)
                slots_reg <= SW'(1);
            if (ctrl.search_init)
            begin
                search_reg <= SW'(1);
                found_reg  <= 1'b0;
                slot_reg   <= '0;
            end
            else if (ctrl.search_step)
            begin
                if (slot_texture[search_reg[IW-1:0]] == id_reg)
                begin
                    found_reg <= 1'b1;
                    slot_reg  <= search_reg[IW-1:0];
                end
                search_reg <= search_reg + SW'(1);
            end
            else if (ctrl.new_slot)
                slot_reg <= ctrl.reset_batch ? IW'(1) : slots_reg[IW-1:0];
            if (ctrl.search_init)
                corner_reg <= '0;
            else if (ctrl.next_corner)
                corner_reg <= corner_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.new_slot)
            slot_texture[ctrl.reset_batch ? IW'(1) : slots_reg[IW-1:0]] <= id_reg;
    end

    assign stat.is_end      = (cmd_reg == CMD_END);
    assign stat.textured    = tex_reg;
    assign stat.batch_full  = ({16'd0, quads_reg} >= 32'(MAX_QUADS));
    assign stat.batch_empty = (quads_reg == 16'd0);
    assign stat.search_done = found_reg || (search_reg >= slots_reg);
    assign stat.found       = found_reg;
    assign stat.slots_full  = (32'(slots_reg) >= TEXTURE_SLOTS);
    assign stat.corner_last = (corner_reg == 2'd3);
    assign stat.out_busy    = out_valid && !out_ready;

    // trig and corner arithmetic
    logic signed [16:0] sin_reg, cos_reg;
    logic signed [63:0] pxc_reg, pys_reg, pxs_reg, pyc_reg;
    logic signed [31:0] vx_reg, vy_reg;
    logic signed [32:0] hx, hy;
    logic signed [49:0] m_xc, m_ys, m_xs, m_yc;
    logic               xneg, yneg;

    assign xneg = (corner_reg == 2'd0) || (corner_reg == 2'd3);
    assign yneg = (corner_reg == 2'd0) || (corner_reg == 2'd1);
    assign hx = xneg ? -33'(w_reg) : 33'(w_reg);
    assign hy = yneg ? -33'(h_reg) : 33'(h_reg);

    assign m_xc = hx * cos_reg;
    assign m_ys = hy * sin_reg;
    assign m_xs = hx * sin_reg;
    assign m_yc = hy * cos_reg;

    function automatic logic signed [31:0] fin(input logic signed [63:0] p,
                                               input logic signed [31:0] c);
        logic signed [63:0] r;
        logic signed [63:0] s;
        r = (p + 64'sd32768) >>> 16;
        s = r + 64'(c);
        if (s > 64'sd2147483647)
            return 32'h7fffffff;
        else if (s < -64'sd2147483648)
            return 32'h80000000;
        return s[31:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (ctrl.trig)
        begin
            sin_reg <= sine_q15(angle_reg);
            cos_reg <= sine_q15(angle_reg + 16'd16384);
        end
        if (ctrl.mul)
        begin
            pxc_reg <= 64'(m_xc);
            pys_reg <= 64'(m_ys);
            pxs_reg <= 64'(m_xs);
            pyc_reg <= 64'(m_yc);
        end
        if (ctrl.sum)
        begin
            vx_reg <= fin(pxc_reg - pys_reg, cx_reg);
            vy_reg <= fin(pxs_reg + pyc_reg, cy_reg);
        end
    end

    // output register
    logic [15:0] tu, tv;
    assign tu = tex_reg ? (xneg ? u_left_reg : u_right_reg) : (xneg ? 16'd0 : 16'd32768);
    assign tv = tex_reg ? (yneg ? v_bottom_reg : v_top_reg) : (yneg ? 16'd0 : 16'd32768);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (ctrl.emit_vert || ctrl.emit_flush)
            out_valid <= 1'b1;
        else if (out_ready)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit_vert)
        begin
            out_user <= KIND_VERTEX;
            out_last <= ctrl.last;
            out_data <= {6'd0, 6'd0, 15'd0, (tex_reg ? tiling_reg : 16'd256),
                         5'(slot_reg), tv, tu, rgba_reg, z_reg, vy_reg, vx_reg};
        end
        else if (ctrl.emit_flush)
        begin
            out_user <= KIND_FLUSH;
            out_last <= ctrl.last;
            out_data <= {6'd0, 6'(slots_reg), quads_reg[14:0], 181'd0};
        end
    end

endmodule
`default_nettype wire

/* tb/sv/sprite_quad_batch_vertex_gen_tb.sv */
// Self-checking bench for sprite_quad_batch_vertex_gen: predicts vertex and flush records
// per quad command and compares every output transaction. Depends on sqbvg_pkg and the RTL.
`default_nettype none
module sprite_quad_batch_vertex_gen_tb;
    import sqbvg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic        cmd;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] z;
        logic [15:0] angle;
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] rgba;
        logic        textured;
        logic [15:0] tex_id;
        logic [15:0] tiling;
    } quad_cmd_t;

    typedef struct {
        logic        kind;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] rgba;
        logic [15:0] u;
        logic [15:0] v;
        logic [4:0]  slot;
        logic [15:0] tiling;
        logic [14:0] bquads;
        logic [5:0]  bslots;
        logic        last;
    } vert_rec_t;

    localparam int SINE_TAB [33] = '{
        0, 1608, 3212, 4808, 6393, 7962, 9512, 11039,
        12540, 14010, 15447, 16846, 18205, 19520, 20788, 22006,
        23170, 24279, 25330, 26320, 27246, 28106, 28899, 29622,
        30274, 30853, 31357, 31786, 32138, 32413, 32610, 32729, 32768};

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [1:0]   cfg_idx;
    logic [15:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [239:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [207:0] m_tdata;
    logic         m_tuser;
    logic         m_tlast;

    sprite_quad_batch_vertex_gen dut (.*);

    vert_rec_t   expected_recs[$];
    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    // predictor state
    logic [15:0] u_left, u_right, v_bottom, v_top;
    int          quads_in_batch;
    int          slots_in_use;
    logic [15:0] slot_tex [32];

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    function automatic longint sine_q15(input logic [15:0] a);
        int pos;
        int idx;
        int frac;
        longint v;
        pos = int'(a[13:0]);
        if (a[14])
            pos = 16384 - pos;
        idx = pos >> 9;
        frac = pos & 511;
        if (idx >= 32)
            v = 32768;
        else
            v = longint'(SINE_TAB[idx] +
                         (((SINE_TAB[idx+1] - SINE_TAB[idx]) * frac + 256) >> 9));
        return a[15] ? -v : v;
    endfunction

    function automatic logic [31:0] sat32(input longint v);
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic void push_flush();
        vert_rec_t r;
        if (quads_in_batch != 0)
        begin
            r = '{default: '0};
            r.kind = KIND_FLUSH;
            r.bquads = quads_in_batch[14:0];
            r.bslots = slots_in_use[5:0];
            expected_recs.push_back(r);
        end
        quads_in_batch = 0;
        slots_in_use = 1;
    endfunction

    function automatic void quad_batch_predict(input quad_cmd_t q);
        vert_rec_t r;
        int        n0;
        int        slot;
        logic [15:0] til;
        longint    s, c, cx, cy, hx, hy, rx, ry;
        n0 = expected_recs.size();
        if (q.cmd == CMD_END)
        begin
            push_flush();
            if (expected_recs.size() > n0)
                expected_recs[$].last = 1'b1;
            return;
        end
        if (quads_in_batch >= MAX_QUADS_DEF)
            push_flush();
        slot = 0;
        til = 16'd256;
        if (q.textured)
        begin
            for (int i = 1; i < slots_in_use; i++)
                if (slot == 0 && slot_tex[i] == q.tex_id)
                    slot = i;
            if (slot == 0)
            begin
                if (slots_in_use >= TEXTURE_SLOTS_DEF)
                    push_flush();
                slot = slots_in_use;
                slot_tex[slot] = q.tex_id;
                slots_in_use++;
            end
            til = q.tiling;
        end
        s = sine_q15(q.angle);
        c = sine_q15(q.angle + 16'd16384);
        cx = longint'($signed(q.cx));
        cy = longint'($signed(q.cy));
        for (int i = 0; i < 4; i++)
        begin
            // corners: (-,-) (+,-) (+,+) (-,+)
            hx = (i == 1 || i == 2) ? longint'($signed(q.w)) : -longint'($signed(q.w));
            hy = (i >= 2) ? longint'($signed(q.h)) : -longint'($signed(q.h));
            rx = (hx * c - hy * s + 32768) >>> 16;
            ry = (hx * s + hy * c + 32768) >>> 16;
            r = '{default: '0};
            r.kind = KIND_VERTEX;
            r.x = sat32(cx + rx);
            r.y = sat32(cy + ry);
            r.z = q.z;
            r.rgba = q.rgba;
            if (q.textured)
            begin
                r.u = (i == 1 || i == 2) ? u_right : u_left;
                r.v = (i >= 2) ? v_top : v_bottom;
            end
            else
            begin
                r.u = (i == 1 || i == 2) ? 16'd32768 : 16'd0;
                r.v = (i >= 2) ? 16'd32768 : 16'd0;
            end
            r.slot = slot[4:0];
            r.tiling = til;
            r.last = (i == 3);
            expected_recs.push_back(r);
        end
        quads_in_batch++;
    endfunction

    // output checker
    always @(posedge clk)
    begin
        vert_rec_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_recs.size() == 0)
            begin
                $error("unexpected output transaction");
                errors++;
            end
            else
            begin
                e = expected_recs.pop_front();
                if (m_tuser !== e.kind)
                begin $error("kind exp %0h got %0h", e.kind, m_tuser); errors++; end
                if (m_tdata[31:0] !== e.x)
                begin $error("vert_x exp %0h got %0h", e.x, m_tdata[31:0]); errors++; end
                if (m_tdata[63:32] !== e.y)
                begin $error("vert_y exp %0h got %0h", e.y, m_tdata[63:32]); errors++; end
                if (m_tdata[95:64] !== e.z)
                begin $error("vert_z exp %0h got %0h", e.z, m_tdata[95:64]); errors++; end
                if (m_tdata[127:96] !== e.rgba)
                begin $error("vert_rgba exp %0h got %0h", e.rgba, m_tdata[127:96]); errors++; end
                if (m_tdata[143:128] !== e.u)
                begin $error("tex_u exp %0h got %0h", e.u, m_tdata[143:128]); errors++; end
                if (m_tdata[159:144] !== e.v)
                begin $error("tex_v exp %0h got %0h", e.v, m_tdata[159:144]); errors++; end
                if (m_tdata[164:160] !== e.slot)
                begin $error("slot exp %0h got %0h", e.slot, m_tdata[164:160]); errors++; end
                if (m_tdata[180:165] !== e.tiling)
                begin
                    $error("vert_tiling exp %0h got %0h", e.tiling, m_tdata[180:165]);
                    errors++;
                end
                if (m_tdata[195:181] !== e.bquads)
                begin
                    $error("batch_quads exp %0h got %0h", e.bquads, m_tdata[195:181]);
                    errors++;
                end
                if (m_tdata[201:196] !== e.bslots)
                begin
                    $error("batch_slots exp %0h got %0h", e.bslots, m_tdata[201:196]);
                    errors++;
                end
                if (m_tlast !== e.last)
                begin $error("last exp %0h got %0h", e.last, m_tlast); errors++; end
            end
        end
    end

    task automatic send_quad(input quad_cmd_t q);
        quad_batch_predict(q);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {q.tiling, q.tex_id, q.rgba, q.h, q.w, q.angle, q.z, q.cy, q.cx};
        s_tuser <= {q.textured, q.cmd};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_recs.size() != 0)
            @(posedge clk);
        // an empty end scene yields nothing; give the block time to settle
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_U_LEFT:   u_left = val;
            REG_U_RIGHT:  u_right = val;
            REG_V_BOTTOM: v_bottom = val;
            default:      v_top = val;
        endcase
        @(posedge clk);
    endtask

    function automatic quad_cmd_t rand_quad();
        quad_cmd_t q;
        q.cmd = ($urandom_range(99) < 4) ? CMD_END : CMD_DRAW;
        q.cx = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 2000000) - 1000000;
        q.cy = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 2000000) - 1000000;
        q.z = $urandom;
        q.angle = 16'($urandom);
        q.w = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 4000000) - 2000000;
        q.h = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 4000000) - 2000000;
        q.rgba = $urandom;
        q.textured = ($urandom_range(99) < 75);
        // small id pool so slots get reused and the table fills up
        q.tex_id = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
        q.tiling = 16'($urandom);
        return q;
    endfunction

    function automatic quad_cmd_t plain_quad(input logic [31:0] cx, input logic [31:0] w,
                                             input logic [15:0] angle);
        quad_cmd_t q;
        q = '{default: '0};
        q.cmd = CMD_DRAW;
        q.cx = cx;
        q.cy = -cx;
        q.z = 32'h8000_0001;
        q.angle = angle;
        q.w = w;
        q.h = w;
        q.rgba = 32'hA5C3_0FF0;
        return q;
    endfunction

    task automatic test_directed();
        quad_cmd_t q;
        q = '{default: '0};
        q.cmd = CMD_END;
        send_quad(q);                                   // empty end scene
        send_quad(plain_quad(32'h0001_0000, 32'h0002_0000, 16'd0));
        send_quad(plain_quad(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd0));    // saturate high
        send_quad(plain_quad(32'h8000_0000, 32'h7FFF_FFFF, 16'd32768)); // saturate low
        send_quad(plain_quad(32'h8000_0000, 32'h8000_0000, 16'd16384));
        send_quad(plain_quad(32'hFFFF_FFFF, 32'h0000_0003, 16'd49152));
        send_quad(plain_quad(32'h0000_0000, 32'hFFFF_FFFF, 16'd65535));
        send_quad(plain_quad(32'h1234_5678, 32'h0000_0001, 16'd255));
        send_quad(plain_quad(32'h0, 32'h0100_0000, 16'd16383));
        q = plain_quad(32'h5555_5555, 32'hAAAA_AAAA, 16'hAAAA);
        q.textured = 1'b1;
        q.tex_id = 16'hFFFF;
        q.tiling = 16'hFFFF;
        q.rgba = 32'hFFFF_FFFF;
        send_quad(q);
        q.tex_id = 16'h0000;
        q.tiling = 16'h0000;
        q.rgba = 32'h0;
        send_quad(q);
        q.tex_id = 16'hFFFF;                            // reused slot
        send_quad(q);
        q.cmd = CMD_END;
        send_quad(q);
        send_quad(q);
        wait_idle();
    endtask

    task automatic test_config_extremes();
        quad_cmd_t q;
        logic [15:0] vals [3] = '{16'd0, 16'd32768, 16'hFFFF};
        for (int k = 0; k < 3; k++)
        begin
            write_reg(REG_U_LEFT, vals[k]);
            write_reg(REG_U_RIGHT, vals[(k + 1) % 3]);
            write_reg(REG_V_BOTTOM, vals[(k + 2) % 3]);
            write_reg(REG_V_TOP, 16'($urandom));
            q = rand_quad();
            q.cmd = CMD_DRAW;
            q.textured = 1'b1;
            send_quad(q);
            q.textured = 1'b0;
            send_quad(q);
            wait_idle();
        end
        write_reg(REG_U_LEFT, 16'd13653);
        write_reg(REG_U_RIGHT, 16'd16384);
        write_reg(REG_V_BOTTOM, 16'd23831);
        write_reg(REG_V_TOP, 16'd26810);
    endtask

    task automatic test_slot_table_full();
        quad_cmd_t q;
        for (int i = 0; i < 34; i++)
        begin
            q = rand_quad();
            q.cmd = CMD_DRAW;
            q.textured = 1'b1;
            q.tex_id = 16'h1000 + i[15:0];
            send_quad(q);
        end
        q.cmd = CMD_END;
        send_quad(q);
        wait_idle();
    endtask

    task automatic test_random(input int n_items);
        for (int i = 0; i < n_items; i++)
            send_quad(rand_quad());
        wait_idle();
        write_reg(REG_U_LEFT, 16'($urandom_range(0, 32768)));
        write_reg(REG_U_RIGHT, 16'($urandom_range(0, 32768)));
        write_reg(REG_V_BOTTOM, 16'($urandom_range(0, 32768)));
        write_reg(REG_V_TOP, 16'($urandom_range(0, 32768)));
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_idx <= REG_U_LEFT;
        cfg_data <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        u_left = 16'd13653;
        u_right = 16'd16384;
        v_bottom = 16'd23831;
        v_top = 16'd26810;
        quads_in_batch = 0;
        slots_in_use = 1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 7;
        recv_idle_pct = 45;
        test_directed();
        test_config_extremes();
        test_slot_table_full();
        test_random(70);
        send_idle_pct = 45;
        recv_idle_pct = 7;
        test_slot_table_full();
        test_random(70);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(70);

        if (errors == 0)
            $display("sprite_quad_batch_vertex_gen test passed");
        else
            $display("sprite_quad_batch_vertex_gen test failed");
        $finish;
    end

    initial
    begin
        #12ms;
        $display("sprite_quad_batch_vertex_gen test failed");
        $finish;
    end
endmodule
`default_nettype wire
